// ===== sv/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Shared widths, codes and helpers for the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int COORD_W  = 16;              // coordinate width, 4 fraction bits
    localparam int DIFF_W   = COORD_W + 1;     // coordinate differences
    localparam int PROD_W   = 2 * DIFF_W;      // product of two differences
    localparam int NUM_W    = PROD_W + 2;      // cross and dot sums, with headroom
    localparam int DEN_W    = NUM_W - 1;       // positive denominator
    localparam int TOL_W    = 16;              // tolerance registers
    localparam int FRAC_W   = 16;              // fraction bits of param tolerance
    localparam int CMP_W    = DEN_W + FRAC_W + 3;  // parameter range compares
    localparam int PNUM_W   = NUM_W + DIFF_W;  // point offset numerator
    localparam int DIV_QB   = DIFF_W + 2;      // quotient bits of the rounding divider
    localparam int DIV_W    = PNUM_W + 2;      // divider remainder width
    localparam int SUM_W    = DIV_QB + 2;      // base plus rounded offset
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_TOL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM_TOL = CFG_IDX_W'(1);

    localparam logic [TOL_W-1:0] CROSS_TOL_RST = TOL_W'(1);
    localparam logic [TOL_W-1:0] PARAM_TOL_RST = TOL_W'(16);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (COORD_W - 1));

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_CROSS   = 2'd1,
        REL_OVERLAP = 2'd2
    } rel_t;

    typedef struct packed {
        logic en;   // whole pipeline advances
    } pipe_ctl_t;

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        logic signed [COORD_W-1:0] a,
        logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

// ===== sv/sic_if.sv =====
// ----------------------------------------------------------------------------
// sic_if
// Valid/ready channels for segment pairs, results and register writes.
// ----------------------------------------------------------------------------
interface sic_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sic_pkg::COORD_W-1:0]    p_start_x;
    logic signed [sic_pkg::COORD_W-1:0]    p_start_y;
    logic signed [sic_pkg::COORD_W-1:0]    p_end_x;
    logic signed [sic_pkg::COORD_W-1:0]    p_end_y;
    logic signed [sic_pkg::COORD_W-1:0]    q_start_x;
    logic signed [sic_pkg::COORD_W-1:0]    q_start_y;
    logic signed [sic_pkg::COORD_W-1:0]    q_end_x;
    logic signed [sic_pkg::COORD_W-1:0]    q_end_y;

    modport source (output valid, p_start_x, p_start_y, p_end_x, p_end_y,
                    q_start_x, q_start_y, q_end_x, q_end_y, input ready);
    modport sink   (input valid, p_start_x, p_start_y, p_end_x, p_end_y,
                    q_start_x, q_start_y, q_end_x, q_end_y, output ready);
endinterface

interface sic_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            relation;
    logic signed [sic_pkg::COORD_W-1:0]    cross_x;
    logic signed [sic_pkg::COORD_W-1:0]    cross_y;

    modport source (output valid, relation, cross_x, cross_y, input ready);
    modport sink   (input valid, relation, cross_x, cross_y, output ready);
endinterface

interface sic_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [sic_pkg::CFG_IDX_W-1:0]         index;
    logic [sic_pkg::TOL_W-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sic_div.sv =====
// ----------------------------------------------------------------------------
// sic_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module sic_div (
    input  logic                          clk,
    input  sic_pkg::pipe_ctl_t            ctl,
    input  logic [sic_pkg::DIV_W-1:0]     num,
    input  logic [sic_pkg::DIV_W-1:0]     den,
    output logic [sic_pkg::DIV_QB-1:0]    quo
);
    logic [sic_pkg::DIV_W-1:0]  rem_reg [sic_pkg::DIV_QB];
    logic [sic_pkg::DIV_W-1:0]  den_reg [sic_pkg::DIV_QB];
    logic [sic_pkg::DIV_QB-1:0] quo_reg [sic_pkg::DIV_QB];

    for (genvar k = 0; k < sic_pkg::DIV_QB; k++) begin : g_step
        localparam int BIT = sic_pkg::DIV_QB - 1 - k;
        logic [sic_pkg::DIV_W-1:0]    rem_cur;
        logic [sic_pkg::DIV_W-1:0]    den_cur;
        logic [sic_pkg::DIV_QB-1:0]   quo_cur;
        logic [sic_pkg::DIV_W:0]      trial;
        logic [sic_pkg::DIV_W-1:0]    rem_next;
        logic [sic_pkg::DIV_QB-1:0]   quo_next;

        // first stage takes the operands, later ones the previous stage
        if (k == 0)
        begin : g_head
            assign rem_cur = num;
            assign den_cur = den;
            assign quo_cur = '0;
        end
        else
        begin : g_link
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign quo_cur = quo_reg[k-1];
        end

        always_comb
        begin
            trial    = {1'b0, rem_cur} - {1'b0, (den_cur << BIT)};
            rem_next = rem_cur;
            quo_next = quo_cur;
            if (!trial[sic_pkg::DIV_W])
            begin
                rem_next      = trial[sic_pkg::DIV_W-1:0];
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_cur;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[sic_pkg::DIV_QB-1];
endmodule

// ===== sv/segment_intersection_classifier_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier_core
// Classifies a pair of 2D segments as crossing, collinear overlap or none.
// ----------------------------------------------------------------------------
// One segment pair per clock in steady state while the output is not stalled;
// each transaction returns exactly one result. The depth is set by the rounding
// divider for the intersection point, which resolves one quotient bit per stage.
// The whole pipeline moves on one enable: it advances whenever the output
// register is empty or being taken, so a stall at the output freezes every stage
// with nothing lost or repeated. Register writes are accepted at any time (ready
// is tied high); the cross tolerance is read in the classify stage and the
// parameter tolerance in the bound stage, so an item already past those stages
// keeps the old value. Write only while empty.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_core (
    input  logic       clk,
    input  logic       rst_n,
    sic_in_if.sink     seg_in,
    sic_out_if.source  res_out,
    sic_cfg_if.sink    cfg
);
    localparam int CW = sic_pkg::COORD_W;
    localparam int DW = sic_pkg::DIFF_W;
    localparam int PW = sic_pkg::PROD_W;
    localparam int NW = sic_pkg::NUM_W;
    localparam int EW = sic_pkg::DEN_W;
    localparam int MW = sic_pkg::CMP_W;
    localparam int AW = sic_pkg::PNUM_W;
    localparam int VW = sic_pkg::DIV_W;
    localparam int QB = sic_pkg::DIV_QB;
    localparam int SW = sic_pkg::SUM_W;
    localparam int FW = sic_pkg::FRAC_W;

    // ---------------- configuration registers ----------------
    logic [sic_pkg::TOL_W-1:0] cross_tol_reg;
    logic [sic_pkg::TOL_W-1:0] param_tol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_tol_reg <= sic_pkg::CROSS_TOL_RST;
            param_tol_reg <= sic_pkg::PARAM_TOL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sic_pkg::CFG_CROSS_TOL: cross_tol_reg <= cfg.data;
                sic_pkg::CFG_PARAM_TOL: param_tol_reg <= cfg.data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    sic_pkg::pipe_ctl_t ctl;
    logic               out_valid_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [QB-1:0]      vd_reg;

    assign ctl.en       = !out_valid_reg || res_out.ready;
    assign seg_in.ready = ctl.en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg        <= seg_in.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            vd_reg        <= {vd_reg[QB-2:0], v6_reg};
            out_valid_reg <= vd_reg[QB-1];
        end
    end

    // ---------------- stage 1: differences ----------------
    // r = Pend - Pstart, s = Qend - Qstart, w = Qstart - Pstart, e = Qend - Pstart
    logic signed [DW-1:0] s1_rx_reg, s1_ry_reg, s1_sx_reg, s1_sy_reg;
    logic signed [DW-1:0] s1_wx_reg, s1_wy_reg, s1_ex_reg, s1_ey_reg;
    logic signed [CW-1:0] s1_px_reg, s1_py_reg, s1_qx_reg, s1_qy_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s1_rx_reg <= sic_pkg::coord_diff(seg_in.p_end_x, seg_in.p_start_x);
            s1_ry_reg <= sic_pkg::coord_diff(seg_in.p_end_y, seg_in.p_start_y);
            s1_sx_reg <= sic_pkg::coord_diff(seg_in.q_end_x, seg_in.q_start_x);
            s1_sy_reg <= sic_pkg::coord_diff(seg_in.q_end_y, seg_in.q_start_y);
            s1_wx_reg <= sic_pkg::coord_diff(seg_in.q_start_x, seg_in.p_start_x);
            s1_wy_reg <= sic_pkg::coord_diff(seg_in.q_start_y, seg_in.p_start_y);
            s1_ex_reg <= sic_pkg::coord_diff(seg_in.q_end_x, seg_in.p_start_x);
            s1_ey_reg <= sic_pkg::coord_diff(seg_in.q_end_y, seg_in.p_start_y);
            s1_px_reg <= seg_in.p_start_x;
            s1_py_reg <= seg_in.p_start_y;
            s1_qx_reg <= seg_in.q_start_x;
            s1_qy_reg <= seg_in.q_start_y;
        end
    end

    // ---------------- stage 2: partial products ----------------
    logic signed [PW-1:0] s2_rs0_reg, s2_rs1_reg, s2_wr0_reg, s2_wr1_reg;
    logic signed [PW-1:0] s2_ws0_reg, s2_ws1_reg, s2_rr0_reg, s2_rr1_reg;
    logic signed [PW-1:0] s2_a00_reg, s2_a01_reg, s2_a10_reg, s2_a11_reg;
    logic signed [DW-1:0] s2_rx_reg, s2_ry_reg, s2_sx_reg, s2_sy_reg;
    logic signed [CW-1:0] s2_px_reg, s2_py_reg, s2_qx_reg, s2_qy_reg;
    logic                 s2_rzero_reg, s2_xdom_reg;
    logic [DW-1:0]        s1_arx, s1_ary;

    assign s1_arx = s1_rx_reg[DW-1] ? DW'(-s1_rx_reg) : DW'(s1_rx_reg);
    assign s1_ary = s1_ry_reg[DW-1] ? DW'(-s1_ry_reg) : DW'(s1_ry_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s2_rs0_reg   <= PW'(s1_rx_reg) * PW'(s1_sy_reg);
            s2_rs1_reg   <= PW'(s1_ry_reg) * PW'(s1_sx_reg);
            s2_wr0_reg   <= PW'(s1_wx_reg) * PW'(s1_ry_reg);
            s2_wr1_reg   <= PW'(s1_wy_reg) * PW'(s1_rx_reg);
            s2_ws0_reg   <= PW'(s1_wx_reg) * PW'(s1_sy_reg);
            s2_ws1_reg   <= PW'(s1_wy_reg) * PW'(s1_sx_reg);
            s2_rr0_reg   <= PW'(s1_rx_reg) * PW'(s1_rx_reg);
            s2_rr1_reg   <= PW'(s1_ry_reg) * PW'(s1_ry_reg);
            s2_a00_reg   <= PW'(s1_wx_reg) * PW'(s1_rx_reg);
            s2_a01_reg   <= PW'(s1_wy_reg) * PW'(s1_ry_reg);
            s2_a10_reg   <= PW'(s1_ex_reg) * PW'(s1_rx_reg);
            s2_a11_reg   <= PW'(s1_ey_reg) * PW'(s1_ry_reg);
            s2_rx_reg    <= s1_rx_reg;
            s2_ry_reg    <= s1_ry_reg;
            s2_sx_reg    <= s1_sx_reg;
            s2_sy_reg    <= s1_sy_reg;
            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_qx_reg    <= s1_qx_reg;
            s2_qy_reg    <= s1_qy_reg;
            s2_rzero_reg <= (s1_rx_reg == '0) && (s1_ry_reg == '0);
            s2_xdom_reg  <= s1_arx > s1_ary;
        end
    end

    // ---------------- stage 3: cross and dot sums ----------------
    logic signed [NW-1:0] s3_rxs_reg, s3_wxr_reg, s3_tn_reg;
    logic signed [NW-1:0] s3_d_reg, s3_a0_reg, s3_a1_reg;
    logic signed [DW-1:0] s3_rx_reg, s3_ry_reg, s3_sx_reg, s3_sy_reg;
    logic signed [CW-1:0] s3_px_reg, s3_py_reg, s3_qx_reg, s3_qy_reg;
    logic                 s3_rzero_reg, s3_xdom_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s3_rxs_reg   <= NW'(s2_rs0_reg) - NW'(s2_rs1_reg);
            s3_wxr_reg   <= NW'(s2_wr0_reg) - NW'(s2_wr1_reg);
            s3_tn_reg    <= NW'(s2_ws0_reg) - NW'(s2_ws1_reg);
            s3_d_reg     <= NW'(s2_rr0_reg) + NW'(s2_rr1_reg);
            s3_a0_reg    <= NW'(s2_a00_reg) + NW'(s2_a01_reg);
            s3_a1_reg    <= NW'(s2_a10_reg) + NW'(s2_a11_reg);
            s3_rx_reg    <= s2_rx_reg;
            s3_ry_reg    <= s2_ry_reg;
            s3_sx_reg    <= s2_sx_reg;
            s3_sy_reg    <= s2_sy_reg;
            s3_px_reg    <= s2_px_reg;
            s3_py_reg    <= s2_py_reg;
            s3_qx_reg    <= s2_qx_reg;
            s3_qy_reg    <= s2_qy_reg;
            s3_rzero_reg <= s2_rzero_reg;
            s3_xdom_reg  <= s2_xdom_reg;
        end
    end

    // ---------------- stage 4: classify, normalize signs ----------------
    // Crossing: den = |r x s|, numerators t and u flipped with its sign.
    // Collinear: den = r.r, numerators are the projections in ascending order.
    logic [NW-1:0]        s3_arxs, s3_awxr;
    logic                 s3_par, s3_col, s3_neg;
    logic signed [NW-1:0] s3_tn_n, s3_un_n;
    sic_pkg::rel_t        s4_mode_next;
    logic [EW-1:0]        s4_den_next;
    logic signed [NW-1:0] s4_n0_next, s4_n1_next;

    sic_pkg::rel_t        s4_mode_reg;
    logic [EW-1:0]        s4_den_reg;
    logic signed [NW-1:0] s4_n0_reg, s4_n1_reg, s4_nsel_reg;
    logic signed [DW-1:0] s4_dx_reg, s4_dy_reg;
    logic signed [CW-1:0] s4_bx_reg, s4_by_reg;

    always_comb
    begin
        s3_neg  = s3_rxs_reg[NW-1];
        s3_arxs = s3_neg ? NW'(-s3_rxs_reg) : NW'(s3_rxs_reg);
        s3_awxr = s3_wxr_reg[NW-1] ? NW'(-s3_wxr_reg) : NW'(s3_wxr_reg);
        s3_par  = (s3_arxs == '0) || (s3_arxs < NW'(cross_tol_reg));
        s3_col  = s3_awxr < NW'(cross_tol_reg);
        s3_tn_n = s3_neg ? -s3_tn_reg : s3_tn_reg;
        s3_un_n = s3_neg ? -s3_wxr_reg : s3_wxr_reg;

        if (s3_rzero_reg || (s3_par && !s3_col))
            s4_mode_next = sic_pkg::REL_NONE;
        else if (s3_par)
            s4_mode_next = sic_pkg::REL_OVERLAP;
        else
            s4_mode_next = sic_pkg::REL_CROSS;

        if (s3_par)
        begin
            s4_den_next = EW'(s3_d_reg);
            if (s3_a0_reg > s3_a1_reg)
            begin
                s4_n0_next = s3_a1_reg;
                s4_n1_next = s3_a0_reg;
            end
            else
            begin
                s4_n0_next = s3_a0_reg;
                s4_n1_next = s3_a1_reg;
            end
        end
        else
        begin
            s4_den_next = EW'(s3_arxs);
            s4_n0_next  = s3_tn_n;
            s4_n1_next  = s3_un_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s4_mode_reg <= s4_mode_next;
            s4_den_reg  <= s4_den_next;
            s4_n0_reg   <= s4_n0_next;
            s4_n1_reg   <= s4_n1_next;
            // point from P along r when |r.x| > |r.y|, else from Q along s
            s4_nsel_reg <= s3_xdom_reg ? s3_tn_n : s3_un_n;
            s4_dx_reg   <= s3_xdom_reg ? s3_rx_reg : s3_sx_reg;
            s4_dy_reg   <= s3_xdom_reg ? s3_ry_reg : s3_sy_reg;
            s4_bx_reg   <= s3_xdom_reg ? s3_px_reg : s3_qx_reg;
            s4_by_reg   <= s3_xdom_reg ? s3_py_reg : s3_qy_reg;
        end
    end

    // ---------------- stage 5: bound and point products ----------------
    sic_pkg::rel_t        s5_mode_reg;
    logic [EW-1:0]        s5_den_reg;
    logic signed [NW-1:0] s5_n0_reg, s5_n1_reg;
    logic [MW-1:0]        s5_lo_reg, s5_hi_reg;
    logic signed [AW-1:0] s5_numx_reg, s5_numy_reg;
    logic signed [CW-1:0] s5_bx_reg, s5_by_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s5_mode_reg <= s4_mode_reg;
            s5_den_reg  <= s4_den_reg;
            s5_n0_reg   <= s4_n0_reg;
            s5_n1_reg   <= s4_n1_reg;
            s5_lo_reg   <= MW'(s4_den_reg) * MW'(param_tol_reg);
            s5_hi_reg   <= MW'(s4_den_reg) * (MW'(param_tol_reg) + (MW'(1) << FW));
            s5_numx_reg <= AW'(s4_nsel_reg) * AW'(s4_dx_reg);
            s5_numy_reg <= AW'(s4_nsel_reg) * AW'(s4_dy_reg);
            s5_bx_reg   <= s4_bx_reg;
            s5_by_reg   <= s4_by_reg;
        end
    end

    // ---------------- stage 6: range tests, divider operands ----------------
    // Parameters are compared scaled by 2^16: -e*den*2^16 <= n*2^16 <= (1+e)*den*2^16.
    logic signed [MW-1:0] s5_n0s, s5_n1s, s5_los, s5_his;
    logic                 s5_n0_in, s5_n1_in, s5_n1_past;
    logic [AW-1:0]        s5_magx, s5_magy;
    sic_pkg::rel_t        s6_rel_next;

    sic_pkg::rel_t        s6_rel_reg;
    logic                 s6_negx_reg, s6_negy_reg;
    logic signed [CW-1:0] s6_bx_reg, s6_by_reg;
    logic [VW-1:0]        s6_nx_reg, s6_ny_reg, s6_dd_reg;

    always_comb
    begin
        s5_n0s     = MW'(s5_n0_reg) <<< FW;
        s5_n1s     = MW'(s5_n1_reg) <<< FW;
        s5_los     = -$signed(s5_lo_reg);
        s5_his     = $signed(s5_hi_reg);
        s5_n0_in   = (s5_n0s >= s5_los) && (s5_n0s <= s5_his);
        s5_n1_in   = (s5_n1s >= s5_los) && (s5_n1s <= s5_his);
        s5_n1_past = s5_n1s > s5_his;
        s5_magx    = s5_numx_reg[AW-1] ? AW'(-s5_numx_reg) : AW'(s5_numx_reg);
        s5_magy    = s5_numy_reg[AW-1] ? AW'(-s5_numy_reg) : AW'(s5_numy_reg);

        case (s5_mode_reg)
            sic_pkg::REL_CROSS:
                s6_rel_next = (s5_n0_in && s5_n1_in) ? sic_pkg::REL_CROSS
                                                     : sic_pkg::REL_NONE;
            sic_pkg::REL_OVERLAP:
                s6_rel_next = (s5_n0_in && s5_n1_past) ? sic_pkg::REL_OVERLAP
                                                       : sic_pkg::REL_NONE;
            default:
                s6_rel_next = sic_pkg::REL_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s6_rel_reg  <= s6_rel_next;
            s6_negx_reg <= s5_numx_reg[AW-1];
            s6_negy_reg <= s5_numy_reg[AW-1];
            s6_bx_reg   <= s5_bx_reg;
            s6_by_reg   <= s5_by_reg;
            // round to nearest, ties away: floor((2|n| + den) / (2 den))
            s6_nx_reg   <= (VW'(s5_magx) << 1) + VW'(s5_den_reg);
            s6_ny_reg   <= (VW'(s5_magy) << 1) + VW'(s5_den_reg);
            s6_dd_reg   <= VW'(s5_den_reg) << 1;
        end
    end

    // ---------------- divider stages ----------------
    logic [QB-1:0] qx, qy;

    sic_div u_div_x (
        .clk (clk),
        .ctl (ctl),
        .num (s6_nx_reg),
        .den (s6_dd_reg),
        .quo (qx)
    );

    sic_div u_div_y (
        .clk (clk),
        .ctl (ctl),
        .num (s6_ny_reg),
        .den (s6_dd_reg),
        .quo (qy)
    );

    // side data rides alongside the divider
    sic_pkg::rel_t        dl_rel_reg  [QB];
    logic                 dl_negx_reg [QB];
    logic                 dl_negy_reg [QB];
    logic signed [CW-1:0] dl_bx_reg   [QB];
    logic signed [CW-1:0] dl_by_reg   [QB];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            dl_rel_reg[0]  <= s6_rel_reg;
            dl_negx_reg[0] <= s6_negx_reg;
            dl_negy_reg[0] <= s6_negy_reg;
            dl_bx_reg[0]   <= s6_bx_reg;
            dl_by_reg[0]   <= s6_by_reg;
            for (int i = 1; i < QB; i++)
            begin
                dl_rel_reg[i]  <= dl_rel_reg[i-1];
                dl_negx_reg[i] <= dl_negx_reg[i-1];
                dl_negy_reg[i] <= dl_negy_reg[i-1];
                dl_bx_reg[i]   <= dl_bx_reg[i-1];
                dl_by_reg[i]   <= dl_by_reg[i-1];
            end
        end
    end

    // ---------------- output stage: offset, saturate ----------------
    logic signed [SW-1:0] offx, offy, sumx, sumy;
    logic signed [CW-1:0] satx, saty;
    logic                 is_cross;

    logic [1:0]           rel_reg;
    logic signed [CW-1:0] cross_x_reg, cross_y_reg;

    always_comb
    begin
        offx     = $signed(SW'(qx));
        offy     = $signed(SW'(qy));
        sumx     = SW'(dl_bx_reg[QB-1]) + (dl_negx_reg[QB-1] ? -offx : offx);
        sumy     = SW'(dl_by_reg[QB-1]) + (dl_negy_reg[QB-1] ? -offy : offy);
        satx     = (sumx > sic_pkg::SAT_MAX) ? CW'(sic_pkg::SAT_MAX) :
                   (sumx < sic_pkg::SAT_MIN) ? CW'(sic_pkg::SAT_MIN) : CW'(sumx);
        saty     = (sumy > sic_pkg::SAT_MAX) ? CW'(sic_pkg::SAT_MAX) :
                   (sumy < sic_pkg::SAT_MIN) ? CW'(sic_pkg::SAT_MIN) : CW'(sumy);
        is_cross = dl_rel_reg[QB-1] == sic_pkg::REL_CROSS;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rel_reg     <= dl_rel_reg[QB-1];
            cross_x_reg <= is_cross ? satx : '0;
            cross_y_reg <= is_cross ? saty : '0;
        end
    end

    assign res_out.valid    = out_valid_reg;
    assign res_out.relation = rel_reg;
    assign res_out.cross_x  = cross_x_reg;
    assign res_out.cross_y  = cross_y_reg;
endmodule

// ===== sv/sic_checker.sv =====
// ----------------------------------------------------------------------------
// sic_checker
// Port-level checks on the classifier result channel, bound to the core.
// ----------------------------------------------------------------------------
module sic_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    out_relation,
    input logic [sic_pkg::COORD_W-1:0]   out_cross_x,
    input logic [sic_pkg::COORD_W-1:0]   out_cross_y
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // only the three defined relations appear
    a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_relation == sic_pkg::REL_NONE ||
                       out_relation == sic_pkg::REL_CROSS ||
                       out_relation == sic_pkg::REL_OVERLAP))
        else $error("undefined relation code");

    // point is zero unless the segments cross
    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_relation != sic_pkg::REL_CROSS
            |-> out_cross_x == '0 && out_cross_y == '0)
        else $error("nonzero point without crossing");

    // an empty output stage never holds back the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
endmodule

bind segment_intersection_classifier_core sic_checker u_sic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (seg_in.ready),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .out_relation (res_out.relation),
    .out_cross_x  (res_out.cross_x),
    .out_cross_y  (res_out.cross_y)
);
